FILE: sv/kre_pkg.sv
`default_nettype none

package kre_pkg;

	// key usage codes with a special meaning
	localparam logic [7:0] CODE_EMPTY    = 8'h00;
	localparam logic [7:0] CODE_ROLLOVER = 8'h01;

	// modifier bit i is reported as scan code base + i
	localparam logic [7:0] MOD_SCAN_BASE = 8'hE0;

	// control characters of the translation table
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_ESC = 8'h1B;
	localparam logic [7:0] CHAR_BS  = 8'h08;
	localparam logic [7:0] CHAR_TAB = 8'h09;

	// per-lane control from the sequencer
	typedef struct packed {
		logic load;
		logic clear;
	} lane_ctrl_t;

	// per-lane status towards the merge logic
	typedef struct packed {
		logic [7:0] held;
		logic       empty;
		logic       match;
		logic       release_req;
	} lane_stat_t;

	// one untranslated event
	typedef struct packed {
		logic [7:0] code;
		logic       down;
	} evt_t;

	// fixed scan code to ascii table, zero where unmapped
	function automatic logic [7:0] ascii_of(input logic [7:0] code);
		logic [7:0] sym;
		sym = 8'h00;
		if (code >= 8'd4 && code <= 8'd29) begin
			sym = 8'h61 + (code - 8'd4);
		end else if (code >= 8'd30 && code <= 8'd38) begin
			sym = 8'h31 + (code - 8'd30);
		end else begin
			case (code)
				8'd39:   sym = 8'h30;
				8'd40:   sym = CHAR_CR;
				8'd41:   sym = CHAR_ESC;
				8'd42:   sym = CHAR_BS;
				8'd43:   sym = CHAR_TAB;
				8'd44:   sym = 8'h20;
				8'd45:   sym = 8'h2D;
				8'd46:   sym = 8'h3D;
				8'd47:   sym = 8'h5B;
				8'd48:   sym = 8'h5D;
				8'd49:   sym = 8'h5C;
				8'd50:   sym = 8'h23;
				8'd51:   sym = 8'h3B;
				8'd52:   sym = 8'h27;
				8'd53:   sym = 8'h60;
				8'd54:   sym = 8'h2C;
				8'd55:   sym = 8'h2E;
				8'd56:   sym = 8'h2F;
				8'd76:   sym = CHAR_BS;
				default: sym = 8'h00;
			endcase
		end
		return sym;
	endfunction

endpackage

`default_nettype wire

FILE: sv/kre_report_if.sv
`default_nettype none

interface kre_report_if;
	logic       valid;
	logic       ready;
	logic [7:0] modifier_bits;
	logic [7:0] key_slot_0;
	logic [7:0] key_slot_1;
	logic [7:0] key_slot_2;
	logic [7:0] key_slot_3;
	logic [7:0] key_slot_4;
	logic [7:0] key_slot_5;

	modport source (
		output valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
		       key_slot_3, key_slot_4, key_slot_5,
		input  ready
	);

	modport sink (
		input  valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
		       key_slot_3, key_slot_4, key_slot_5,
		output ready
	);
endinterface

`default_nettype wire

FILE: sv/kre_event_if.sv
`default_nettype none

interface kre_event_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       raw_code;
	logic       key_down;
	logic       last_event;

	modport source (
		output valid, symbol, raw_code, key_down, last_event,
		input  ready
	);

	modport sink (
		input  valid, symbol, raw_code, key_down, last_event,
		output ready
	);
endinterface

`default_nettype wire

FILE: sv/keyboard_report_to_key_events.sv
// Boot keyboard report decoder: one report in, up to twenty key events out.
// Steps per report: a press scan of the KEY_SLOTS slots, one slot a cycle while
// the output takes events, then one step per release and per modifier event,
// then a flush. Each event waits one stage for the next one or the end of the scan
// before it moves to the output register; last_event marks the final one.
// Reset clears held keys, held modifiers and all valid flags at once.
`default_nettype none

module keyboard_report_to_key_events #(
	parameter int KEY_SLOTS      = 6,
	parameter int MODIFIER_COUNT = 8
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	kre_report_if.sink   report,
	kre_event_if.source  events
);

	localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRESS,
		S_KREL,
		S_MOD,
		S_FLUSH
	} state_t;

	state_t                    state_q;
	logic [IDX_W-1:0]          idx_q;
	logic [MODIFIER_COUNT-1:0] held_mods_q;
	logic [MODIFIER_COUNT-1:0] mods_q;
	logic [7:0]                cur_q [KEY_SLOTS];
	logic [7:0]                rep_codes [6];

	kre_pkg::lane_ctrl_t       lane_ctrl [KEY_SLOTS];
	kre_pkg::lane_stat_t       lane_stat [KEY_SLOTS];

	logic [7:0]                cand;
	logic                      any_match;
	logic                      free_found;
	logic [IDX_W-1:0]          free_idx;
	logic                      press_ev;
	logic                      rel_any;
	logic [IDX_W-1:0]          rel_idx;
	logic [7:0]                rel_code;
	logic [MODIFIER_COUNT-1:0] mod_press;
	logic [MODIFIER_COUNT-1:0] mod_rel;
	logic [MODIFIER_COUNT-1:0] mod_sel;
	logic [MODIFIER_COUNT-1:0] mod_low;
	logic [7:0]                mod_code;
	logic                      gen_valid;
	kre_pkg::evt_t             gen_evt;
	logic                      adv;
	logic                      take;
	logic                      fin_done;
	logic                      accept;

	assign report.ready = (state_q == S_IDLE);
	assign accept       = report.valid && report.ready;

	assign rep_codes[0] = report.key_slot_0;
	assign rep_codes[1] = report.key_slot_1;
	assign rep_codes[2] = report.key_slot_2;
	assign rep_codes[3] = report.key_slot_3;
	assign rep_codes[4] = report.key_slot_4;
	assign rep_codes[5] = report.key_slot_5;

	// report capture
	always_ff @(posedge clk) begin
		if (accept) begin
			mods_q <= report.modifier_bits[MODIFIER_COUNT-1:0];
			for (int k = 0; k < KEY_SLOTS; k++) begin
				cur_q[k] <= rep_codes[k];
			end
		end
	end

	// held key lanes
	for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
		kre_lane #(
			.KEY_SLOTS (KEY_SLOTS)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (lane_ctrl[g]),
			.cand     (cand),
			.own_code (cur_q[g]),
			.cur      (cur_q),
			.stat     (lane_stat[g])
		);
	end

	// merge lane results: match, first free slot, first release
	assign cand = cur_q[idx_q];

	always_comb begin
		any_match  = 1'b0;
		free_found = 1'b0;
		free_idx   = '0;
		rel_any    = 1'b0;
		rel_idx    = '0;
		rel_code   = kre_pkg::CODE_EMPTY;
		for (int k = 0; k < KEY_SLOTS; k++) begin
			if (lane_stat[k].match) begin
				any_match = 1'b1;
			end
			if (lane_stat[k].empty && !free_found) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(k);
			end
			if (lane_stat[k].release_req && !rel_any) begin
				rel_any  = 1'b1;
				rel_idx  = IDX_W'(k);
				rel_code = lane_stat[k].held;
			end
		end
	end

	assign press_ev = (cand != kre_pkg::CODE_EMPTY) &&
	                  (cand != kre_pkg::CODE_ROLLOVER) && !any_match;

	// modifier changes, presses before releases, lowest bit first
	assign mod_press = mods_q & ~held_mods_q;
	assign mod_rel   = held_mods_q & ~mods_q;
	assign mod_sel   = (mod_press != '0) ? mod_press : mod_rel;
	assign mod_low   = mod_sel & (~mod_sel + MODIFIER_COUNT'(1));

	always_comb begin
		mod_code = kre_pkg::MOD_SCAN_BASE;
		for (int k = 0; k < MODIFIER_COUNT; k++) begin
			if (mod_low[k]) begin
				mod_code = kre_pkg::MOD_SCAN_BASE + 8'(k);
			end
		end
	end

	// event generation for the current step
	always_comb begin
		gen_valid    = 1'b0;
		gen_evt.code = cand;
		gen_evt.down = 1'b1;
		unique case (state_q)
			S_PRESS: begin
				gen_valid    = press_ev;
				gen_evt.code = cand;
				gen_evt.down = 1'b1;
			end
			S_KREL: begin
				gen_valid    = rel_any;
				gen_evt.code = rel_code;
				gen_evt.down = 1'b0;
			end
			S_MOD: begin
				gen_valid    = (mod_sel != '0);
				gen_evt.code = mod_code;
				gen_evt.down = (mod_press != '0);
			end
			S_IDLE, S_FLUSH: begin
				gen_valid = 1'b0;
			end
			default: begin
				gen_valid = 1'b0;
			end
		endcase
	end

	assign adv = !gen_valid || take;

	// lane updates
	always_comb begin
		for (int k = 0; k < KEY_SLOTS; k++) begin
			lane_ctrl[k].load  = (state_q == S_PRESS) && press_ev && adv &&
			                     free_found && (free_idx == IDX_W'(k));
			lane_ctrl[k].clear = (state_q == S_KREL) && rel_any && adv &&
			                     (rel_idx == IDX_W'(k));
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			held_mods_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= S_PRESS;
					end
				end
				S_PRESS: begin
					if (adv) begin
						if (idx_q == IDX_W'(KEY_SLOTS - 1)) begin
							state_q <= S_KREL;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				S_KREL: begin
					if (!rel_any) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_sel == '0) begin
						state_q <= S_FLUSH;
					end else if (adv) begin
						if (mod_press != '0) begin
							held_mods_q <= held_mods_q | mod_low;
						end else begin
							held_mods_q <= held_mods_q & ~mod_low;
						end
					end
				end
				S_FLUSH: begin
					if (fin_done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output staging and translation
	kre_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (gen_valid),
		.push_evt   (gen_evt),
		.finish     (state_q == S_FLUSH),
		.take       (take),
		.fin_done   (fin_done),
		.events     (events)
	);

endmodule

`default_nettype wire

FILE: sv/kre_lane.sv
`default_nettype none

module kre_lane #(
	parameter int KEY_SLOTS = 6
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire kre_pkg::lane_ctrl_t  ctrl,
	input  wire logic [7:0]           cand,
	input  wire logic [7:0]           own_code,
	input  wire logic [7:0]           cur [KEY_SLOTS],
	output kre_pkg::lane_stat_t       stat
);

	logic [7:0] held_q;
	logic       in_cur;

	// one held key slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= kre_pkg::CODE_EMPTY;
		end else if (ctrl.load) begin
			held_q <= cand;
		end else if (ctrl.clear) begin
			held_q <= kre_pkg::CODE_EMPTY;
		end
	end

	// is the held key still in the report
	always_comb begin
		in_cur = 1'b0;
		for (int k = 0; k < KEY_SLOTS; k++) begin
			if (cur[k] == held_q) begin
				in_cur = 1'b1;
			end
		end
	end

	// lane status
	always_comb begin
		stat.held        = held_q;
		stat.empty       = (held_q == kre_pkg::CODE_EMPTY);
		stat.match       = (held_q == cand);
		stat.release_req = (held_q != kre_pkg::CODE_EMPTY) &&
		                   (own_code != kre_pkg::CODE_ROLLOVER) && !in_cur;
	end

endmodule

`default_nettype wire

FILE: sv/kre_out_stage.sv
`default_nettype none

module kre_out_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	input  wire kre_pkg::evt_t  push_evt,
	input  wire logic           finish,
	output logic                take,
	output logic                fin_done,
	kre_event_if.source         events
);

	logic       pend_valid_q;
	logic [7:0] pend_symbol_q;
	logic       pend_raw_q;
	logic       pend_down_q;
	logic       out_valid_q;
	logic [7:0] out_symbol_q;
	logic       out_raw_q;
	logic       out_down_q;
	logic       out_last_q;
	logic       out_free;
	logic       move;
	logic       push;
	logic [7:0] sym;

	// one event is held back until it is known whether another follows
	assign out_free = !out_valid_q || events.ready;
	assign take     = !pend_valid_q || out_free;
	assign fin_done = !pend_valid_q || out_free;
	assign move     = pend_valid_q && out_free && (push_valid || finish);
	assign push     = push_valid && take;
	assign sym      = kre_pkg::ascii_of(push_evt.code);

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push) begin
				pend_valid_q <= 1'b1;
			end else if (move) begin
				pend_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (events.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// translated payload
	always_ff @(posedge clk) begin
		if (push) begin
			pend_symbol_q <= (sym == 8'h00) ? push_evt.code : sym;
			pend_raw_q    <= (sym == 8'h00);
			pend_down_q   <= push_evt.down;
		end
		if (move) begin
			out_symbol_q <= pend_symbol_q;
			out_raw_q    <= pend_raw_q;
			out_down_q   <= pend_down_q;
			out_last_q   <= finish;
		end
	end

	assign events.valid      = out_valid_q;
	assign events.symbol     = out_symbol_q;
	assign events.raw_code   = out_raw_q;
	assign events.key_down   = out_down_q;
	assign events.last_event = out_last_q;

endmodule

`default_nettype wire

FILE: dv/tb.sv
`default_nettype none

module tb;

	// one key event as it leaves the decoder
	typedef struct packed {
		logic [7:0] symbol;
		logic       raw_code;
		logic       key_down;
		logic       last_event;
	} key_event_t;

	// how a directed row gets its expected events
	typedef enum logic [1:0] {
		FROM_DECODER,
		NO_EVENTS,
		ONE_EVENT
	} row_check_t;

	// one directed report, key slots packed with slot 0 in the low byte
	typedef struct packed {
		logic [7:0]  mods;
		logic [47:0] keys;
		row_check_t  check;
		key_event_t  typed;
	} stim_row_t;

	localparam key_event_t NO_EV = '0;
	localparam int DIR_ROWS = 25;
	localparam int RANDOM_PER_PHASE = 100;
	localparam int CHOKE_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;

	// directed reports, key slots written slot 5 down to slot 0
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		// nothing held straight after reset
		'{8'h00, 48'h000000000000, NO_EVENTS, NO_EV},
		// press and release of 'a'
		'{8'h00, 48'h000000000004, ONE_EVENT, '{8'h61, 1'b0, 1'b1, 1'b1}},
		'{8'h00, 48'h000000000000, ONE_EVENT, '{8'h61, 1'b0, 1'b0, 1'b1}},
		// left ctrl press and release, always raw
		'{8'h01, 48'h000000000000, ONE_EVENT,
			'{kre_pkg::MOD_SCAN_BASE, 1'b1, 1'b1, 1'b1}},
		'{8'h00, 48'h000000000000, ONE_EVENT,
			'{kre_pkg::MOD_SCAN_BASE, 1'b1, 1'b0, 1'b1}},
		// top code is unmapped
		'{8'h00, 48'h0000000000FF, ONE_EVENT, '{8'hFF, 1'b1, 1'b1, 1'b1}},
		'{8'h00, 48'h000000000000, ONE_EVENT, '{8'hFF, 1'b1, 1'b0, 1'b1}},
		// rollover on every slot with nothing held
		'{8'h00, 48'h010101010101, NO_EVENTS, NO_EV},
		// control characters, the second backspace code and slash
		'{8'h00, 48'h384C2B2A2928, FROM_DECODER, NO_EV},
		'{8'h00, 48'h000000000000, FROM_DECODER, NO_EV},
		// fill every held slot
		'{8'h00, 48'h090807060504, FROM_DECODER, NO_EV},
		// new key while held slots are full, then again once there is room
		'{8'h00, 48'h09080706050A, FROM_DECODER, NO_EV},
		'{8'h00, 48'h09080706050A, FROM_DECODER, NO_EV},
		// rollover in one slot keeps the key held at that index
		'{8'h00, 48'h09080706010A, FROM_DECODER, NO_EV},
		// all new keys with full slots and all modifiers: longest burst
		'{8'hFF, 48'h151413121110, FROM_DECODER, NO_EV},
		'{8'h00, 48'h000000000000, FROM_DECODER, NO_EV},
		// duplicate codes in one report
		'{8'h00, 48'h000000000505, FROM_DECODER, NO_EV},
		'{8'h00, 48'h000000050000, FROM_DECODER, NO_EV},
		// alternating modifier patterns
		'{8'hAA, 48'h000000000000, FROM_DECODER, NO_EV},
		'{8'h55, 48'h39382D2C271E, FROM_DECODER, NO_EV},
		'{8'h00, 48'h000000000000, FROM_DECODER, NO_EV},
		// modifier scan code arriving as a key
		'{8'h80, 48'h0000000000E3, FROM_DECODER, NO_EV},
		'{8'h00, 48'h000000000000, FROM_DECODER, NO_EV},
		// every field at its top value, then unplug
		'{8'hFF, 48'hFFFFFFFFFFFF, FROM_DECODER, NO_EV},
		'{8'h00, 48'h000000000000, FROM_DECODER, NO_EV}
	};

	logic clk;
	logic arst_n;

	kre_report_if rep();
	kre_event_if  evq();

	keyboard_report_to_key_events uut (
		.clk    (clk),
		.arst_n (arst_n),
		.report (rep),
		.events (evq)
	);

	// shadow of the decoder state
	logic [7:0] shadow_keys [6];
	logic [7:0] shadow_mods;

	// keyboard being "typed" on by the random part
	logic [7:0]  kb_mods;
	logic [47:0] kb_keys;

	key_event_t pending_events [$];

	int mismatches = 0;
	int events_checked = 0;
	int reports_sent = 0;
	int longest_burst = 0;
	int cycles = 0;
	int src_idle_pct = 38;
	int sink_idle_pct = 81;
	bit choke_pending = 1'b0;
	int choke_left = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// scan code to ascii, zero where the code has no character
	function automatic logic [7:0] scan_to_char(input logic [7:0] code);
		string alnum;
		string punct;
		alnum = "abcdefghijklmnopqrstuvwxyz1234567890";
		punct = " -=[]\\#;'`,./";
		if (code >= 8'd4 && code <= 8'd39) begin
			return alnum[code - 8'd4];
		end
		if (code >= 8'd44 && code <= 8'd56) begin
			return punct[code - 8'd44];
		end
		case (code)
			8'd40: return kre_pkg::CHAR_CR;
			8'd41: return kre_pkg::CHAR_ESC;
			8'd42: return kre_pkg::CHAR_BS;
			8'd43: return kre_pkg::CHAR_TAB;
			8'd76: return kre_pkg::CHAR_BS;
			default: return 8'h00;
		endcase
	endfunction

	function automatic key_event_t make_event(input logic [7:0] code, input logic down);
		key_event_t e;
		logic [7:0] c;
		c = scan_to_char(code);
		e.symbol     = (c == 8'h00) ? code : c;
		e.raw_code   = (c == 8'h00);
		e.key_down   = down;
		e.last_event = 1'b0;
		return e;
	endfunction

	function automatic bit listed(input logic [7:0] code, input logic [7:0] list [6]);
		for (int i = 0; i < 6; i++) begin
			if (list[i] == code) return 1'b1;
		end
		return 1'b0;
	endfunction

	// works out the events of one report and moves the shadow state on
	function automatic void decode_report(input logic [7:0] m, input logic [47:0] k,
		output key_event_t evs [$]);
		logic [7:0] cur [6];
		logic [7:0] code;
		evs = {};
		for (int i = 0; i < 6; i++) cur[i] = k[i*8 +: 8];

		// presses, stored in the first free slot when there is one
		for (int i = 0; i < 6; i++) begin
			code = cur[i];
			if (code == kre_pkg::CODE_EMPTY || code == kre_pkg::CODE_ROLLOVER) continue;
			if (!listed(code, shadow_keys)) begin
				for (int j = 0; j < 6; j++) begin
					if (shadow_keys[j] == kre_pkg::CODE_EMPTY) begin
						shadow_keys[j] = code;
						break;
					end
				end
				evs.push_back(make_event(code, 1'b1));
			end
		end

		// releases, skipping slots that report rollover
		for (int i = 0; i < 6; i++) begin
			if (cur[i] == kre_pkg::CODE_ROLLOVER) continue;
			code = shadow_keys[i];
			if (code == kre_pkg::CODE_EMPTY) continue;
			if (!listed(code, cur)) begin
				for (int j = 0; j < 6; j++) begin
					if (shadow_keys[j] == code) begin
						shadow_keys[j] = kre_pkg::CODE_EMPTY;
						break;
					end
				end
				evs.push_back(make_event(code, 1'b0));
			end
		end

		// modifier presses then releases
		for (int i = 0; i < 8; i++) begin
			if (m[i] && !shadow_mods[i]) begin
				shadow_mods[i] = 1'b1;
				evs.push_back(make_event(kre_pkg::MOD_SCAN_BASE + 8'(i), 1'b1));
			end
		end
		for (int i = 0; i < 8; i++) begin
			if (shadow_mods[i] && !m[i]) begin
				shadow_mods[i] = 1'b0;
				evs.push_back(make_event(kre_pkg::MOD_SCAN_BASE + 8'(i), 1'b0));
			end
		end

		if (evs.size() > 0) evs[evs.size() - 1].last_event = 1'b1;
	endfunction

	// mostly mapped keys, some unmapped, some anything
	function automatic logic [7:0] pick_code();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return 8'($urandom_range(4, 56));
		if (r < 8) return 8'($urandom_range(57, 255));
		return 8'($urandom_range(0, 255));
	endfunction

	// next report of the random part: small edits to a held keyboard,
	// with unplugs, rollover and pure noise mixed in
	task automatic shape_report(output logic [7:0] m, output logic [47:0] k);
		int pick;
		int a;
		int b;
		pick = $urandom_range(0, 99);
		a = $urandom_range(0, 5);
		b = $urandom_range(0, 5);
		if (pick < 50) begin
			if ($urandom_range(0, 2) == 0) kb_keys[a*8 +: 8] = kre_pkg::CODE_EMPTY;
			else kb_keys[a*8 +: 8] = pick_code();
		end else if (pick < 65) begin
			kb_mods = kb_mods ^ (8'h01 << $urandom_range(0, 7));
		end else if (pick < 80) begin
			kb_keys[b*8 +: 8] = kb_keys[a*8 +: 8];
		end else if (pick < 86) begin
			kb_keys = '0;
			kb_mods = '0;
		end else if (pick < 92) begin
			kb_keys = {32'($urandom()), 16'($urandom())};
			kb_mods = 8'($urandom());
		end
		m = kb_mods;
		k = kb_keys;
		// rollover reports leave the keyboard itself unchanged
		if (pick >= 92) begin
			if ($urandom_range(0, 1) == 0) k = {6{kre_pkg::CODE_ROLLOVER}};
			else k[a*8 +: 8] = kre_pkg::CODE_ROLLOVER;
		end
	endtask

	// offer one report, queue its events once the request is taken
	task automatic send_report(input logic [7:0] m, input logic [47:0] k,
		input row_check_t check, input key_event_t typed);
		key_event_t burst [$];
		while ($urandom_range(0, 99) < src_idle_pct) begin
			rep.valid <= 1'b0;
			@(posedge clk);
		end
		rep.valid         <= 1'b1;
		rep.modifier_bits <= m;
		rep.key_slot_0    <= k[7:0];
		rep.key_slot_1    <= k[15:8];
		rep.key_slot_2    <= k[23:16];
		rep.key_slot_3    <= k[31:24];
		rep.key_slot_4    <= k[39:32];
		rep.key_slot_5    <= k[47:40];
		@(posedge clk);
		while (!rep.ready) @(posedge clk);

		decode_report(m, k, burst);
		if (burst.size() > longest_burst) longest_burst = burst.size();
		if (check == NO_EVENTS) begin
			burst.delete();
		end else if (check == ONE_EVENT) begin
			burst.delete();
			burst.push_back(typed);
		end
		foreach (burst[i]) pending_events.push_back(burst[i]);
		reports_sent++;
	endtask

	// one line per mismatch
	task automatic flag_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		mismatches++;
	endtask

	// event receiver: random idling, plus one long choke on request
	always @(posedge clk) begin
		if (choke_left > 0) begin
			evq.ready  <= 1'b0;
			choke_left <= choke_left - 1;
		end else if (choke_pending) begin
			evq.ready     <= 1'b0;
			choke_left    <= CHOKE_CYCLES;
			choke_pending <= 1'b0;
		end else begin
			evq.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// compare each event with the oldest expectation
	always @(posedge clk) begin
		key_event_t want;
		if (arst_n && evq.valid && evq.ready) begin
			events_checked++;
			if (pending_events.size() == 0) begin
				flag_mismatch($sformatf("event %02h with none expected", evq.symbol));
			end else begin
				want = pending_events.pop_front();
				if (evq.symbol !== want.symbol)
					flag_mismatch($sformatf("symbol %02h, want %02h",
						evq.symbol, want.symbol));
				if (evq.raw_code !== want.raw_code)
					flag_mismatch($sformatf("raw_code %b, want %b on symbol %02h",
						evq.raw_code, want.raw_code, want.symbol));
				if (evq.key_down !== want.key_down)
					flag_mismatch($sformatf("key_down %b, want %b on symbol %02h",
						evq.key_down, want.key_down, want.symbol));
				if (evq.last_event !== want.last_event)
					flag_mismatch($sformatf("last_event %b, want %b on symbol %02h",
						evq.last_event, want.last_event, want.symbol));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events outstanding",
				cycles, pending_events.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		logic [7:0]  m;
		logic [47:0] k;
		rep.valid         = 1'b0;
		rep.modifier_bits = '0;
		rep.key_slot_0    = '0;
		rep.key_slot_1    = '0;
		rep.key_slot_2    = '0;
		rep.key_slot_3    = '0;
		rep.key_slot_4    = '0;
		rep.key_slot_5    = '0;
		evq.ready         = 1'b0;
		arst_n            = 1'b0;
		for (int i = 0; i < 6; i++) shadow_keys[i] = kre_pkg::CODE_EMPTY;
		shadow_mods = '0;
		kb_mods     = '0;
		kb_keys     = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed reports
		for (int i = 0; i < DIR_ROWS; i++) begin
			send_report(DIR_TABLE[i].mods, DIR_TABLE[i].keys, DIR_TABLE[i].check,
				DIR_TABLE[i].typed);
		end

		// random reports in three idling phases
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  = 38;
					sink_idle_pct = 81;
				end
				1: begin
					src_idle_pct  = 81;
					sink_idle_pct = 38;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
					// long receiver stall while reports keep coming
					choke_pending = 1'b1;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				shape_report(m, k);
				send_report(m, k, FROM_DECODER, NO_EV);
			end
		end
		rep.valid <= 1'b0;

		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d reports (%0d directed) decoded, %0d key events checked",
			reports_sent, DIR_ROWS, events_checked);
		$display("longest burst %0d events, receiver choked once for %0d cycles",
			longest_burst, CHOKE_CYCLES);
		if (mismatches == 0 && pending_events.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
